// ===== rtl/aabbpb_pkg.sv =====
// shared constants, register codes and stage control types for the push-back resolver
// no dependencies; imported by every module of the block
package aabbpb_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int HALF_BITS      = 31;
   localparam int SQ_BITS        = 2 * HALF_BITS;
   localparam int DIST_BITS      = SQ_BITS + 2;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [HALF_BITS-1:0] BOX_HALF_RESET = HALF_BITS'(65536);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_HALF_X = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_HALF_Y = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_HALF_Z = CSR_IDX_BITS'(2);

   // other shape kind
   localparam logic OP_BOX    = 1'b0;
   localparam logic OP_SPHERE = 1'b1;

   typedef struct packed {
      logic valid;
      logic sphere;
      logic miss;
   } stage_ctl_type;

endpackage

// ===== rtl/aabb_push_back_resolver.sv =====
// top level of the box push-back resolver: half-extent registers, stall control, pipeline
// depends on aabbpb_pkg, aabbpb_bounds, aabbpb_gap, aabbpb_resolve
//
//   channel   dir   handshake              payload
//   req       in    req_valid / req_ready  op, self and other centers, other half extents
//   rsp       out   rsp_valid / rsp_ready  hit, push_x/y/z, moved_x/y/z
//   csr       in    csr_we                 csr_index, csr_wdata (box half extents)
//
// five register stages, one item per cycle sustained while results are taken
// stage depth is set by the 31x31 squared-distance multipliers and the 64-bit distance sum
// the whole pipeline advances together when the result register is empty or taken,
// so a stall holds every stage in place and req_ready equals that advance condition
// synchronous reset clears the valid bits and sets each half extent to 1.0

module aabb_push_back_resolver import aabbpb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [COORD_BITS-1:0]  req_self_center_x,
   input  logic signed [COORD_BITS-1:0]  req_self_center_y,
   input  logic signed [COORD_BITS-1:0]  req_self_center_z,
   input  logic signed [COORD_BITS-1:0]  req_other_center_x,
   input  logic signed [COORD_BITS-1:0]  req_other_center_y,
   input  logic signed [COORD_BITS-1:0]  req_other_center_z,
   input  logic        [HALF_BITS-1:0]   req_other_half_x,
   input  logic        [HALF_BITS-1:0]   req_other_half_y,
   input  logic        [HALF_BITS-1:0]   req_other_half_z,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_BITS-1:0]  rsp_push_x,
   output logic signed [COORD_BITS-1:0]  rsp_push_y,
   output logic signed [COORD_BITS-1:0]  rsp_push_z,
   output logic signed [COORD_BITS-1:0]  rsp_moved_x,
   output logic signed [COORD_BITS-1:0]  rsp_moved_y,
   output logic signed [COORD_BITS-1:0]  rsp_moved_z,
   // register writes
   input  logic                          csr_we,
   input  logic        [CSR_IDX_BITS-1:0] csr_index,
   input  logic        [HALF_BITS-1:0]   csr_wdata
);

   localparam int EW = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 3;

   // own box half extents
   logic [HALF_BITS-1:0] box_half_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_half_ff[i] <= BOX_HALF_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_HALF_X: box_half_ff[0] <= csr_wdata;
            CSR_BOX_HALF_Y: box_half_ff[1] <= csr_wdata;
            CSR_BOX_HALF_Z: box_half_ff[2] <= csr_wdata;
            default: ;  // index beyond the register list is ignored
         endcase
      end
   end

   // whole pipeline moves when the result register is free
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic signed [COORD_BITS-1:0] self_c [3], other_c [3];
   logic        [HALF_BITS-1:0]  other_h [3];

   assign self_c  = '{req_self_center_x, req_self_center_y, req_self_center_z};
   assign other_c = '{req_other_center_x, req_other_center_y, req_other_center_z};
   assign other_h = '{req_other_half_x, req_other_half_y, req_other_half_z};

   // stages one and two
   stage_ctl_type               ctl2;
   logic signed [EW-1:0]        p2 [3], q2 [3];
   logic        [HALF_BITS-1:0] d2 [3];
   logic signed [COORD_BITS-1:0] oc2 [3];
   logic        [HALF_BITS-1:0] r2;

   aabbpb_bounds #(.COORD_BITS(COORD_BITS)) u_bounds (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_sphere (req_op == OP_SPHERE),
      .self_c    (self_c),
      .other_c   (other_c),
      .other_h   (other_h),
      .box_h     (box_half_ff),
      .ctl_out   (ctl2),
      .p_out     (p2),
      .q_out     (q2),
      .d_out     (d2),
      .oc_out    (oc2),
      .r_out     (r2)
   );

   // stage three
   stage_ctl_type               ctl3;
   logic signed [EW-1:0]        gap3 [3];
   logic        [EW-1:0]        gmag3 [3];
   logic        [SQ_BITS-1:0]   sq3 [3];
   logic        [SQ_BITS-1:0]   rsq3;
   logic signed [COORD_BITS-1:0] oc3 [3];

   aabbpb_gap #(.COORD_BITS(COORD_BITS)) u_gap (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (ctl2),
      .p_in     (p2),
      .q_in     (q2),
      .d_in     (d2),
      .oc_in    (oc2),
      .r_in     (r2),
      .ctl_out  (ctl3),
      .gap_out  (gap3),
      .gmag_out (gmag3),
      .sq_out   (sq3),
      .rsq_out  (rsq3),
      .oc_out   (oc3)
   );

   // stages four and five
   logic signed [COORD_BITS-1:0] push5 [3], moved5 [3];

   aabbpb_resolve #(.COORD_BITS(COORD_BITS)) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl_in    (ctl3),
      .gap_in    (gap3),
      .gmag_in   (gmag3),
      .sq_in     (sq3),
      .rsq_in    (rsq3),
      .oc_in     (oc3),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_push  (push5),
      .out_moved (moved5)
   );

   assign rsp_push_x  = push5[0];
   assign rsp_push_y  = push5[1];
   assign rsp_push_z  = push5[2];
   assign rsp_moved_x = moved5[0];
   assign rsp_moved_y = moved5[1];
   assign rsp_moved_z = moved5[2];

endmodule

// ===== rtl/aabbpb_bounds.sv =====
// stages one and two: shape bounds per axis, then gap candidates, sphere distance and
// separation flags; depends on aabbpb_pkg
module aabbpb_bounds import aabbpb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic                         in_sphere,
   input  logic signed [COORD_BITS-1:0] self_c  [3],
   input  logic signed [COORD_BITS-1:0] other_c [3],
   input  logic        [HALF_BITS-1:0]  other_h [3],
   input  logic        [HALF_BITS-1:0]  box_h   [3],
   output stage_ctl_type                ctl_out,
   output logic signed [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] p_out [3],
   output logic signed [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] q_out [3],
   output logic        [HALF_BITS-1:0]  d_out   [3],
   output logic signed [COORD_BITS-1:0] oc_out  [3],
   output logic        [HALF_BITS-1:0]  r_out
);

   localparam int EW = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 3;

   // stage one
   stage_ctl_type               s1_ctl_ff;
   logic signed [EW-1:0]        smin_ff [3], smax_ff [3], omin_ff [3], omax_ff [3];
   logic signed [EW-1:0]        smin_in [3], smax_in [3], omin_in [3], omax_in [3];
   logic signed [COORD_BITS-1:0] oc1_ff [3];
   logic [HALF_BITS-1:0]        r1_ff;

   logic signed [EW-1:0] sc_e [3], oc_e [3], sh_e [3], oh_e [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sc_e[i] = EW'(self_c[i]);
         oc_e[i] = EW'(other_c[i]);
         sh_e[i] = $signed({{(EW-HALF_BITS){1'b0}}, box_h[i]});
         // a sphere uses its radius on every axis
         oh_e[i] = $signed({{(EW-HALF_BITS){1'b0}}, in_sphere ? other_h[0] : other_h[i]});
         smin_in[i] = sc_e[i] - sh_e[i];
         smax_in[i] = sc_e[i] + sh_e[i];
         omin_in[i] = oc_e[i] - oh_e[i];
         omax_in[i] = oc_e[i] + oh_e[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= '{valid: in_valid, sphere: in_sphere, miss: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            smin_ff[i] <= smin_in[i];
            smax_ff[i] <= smax_in[i];
            omin_ff[i] <= omin_in[i];
            omax_ff[i] <= omax_in[i];
            oc1_ff[i]  <= other_c[i];
         end
         r1_ff <= other_h[0];
      end
   end

   // stage two
   stage_ctl_type               s2_ctl_ff, s2_ctl_in;
   logic signed [EW-1:0]        p_ff [3], q_ff [3], p_in [3], q_in [3];
   logic [HALF_BITS-1:0]        d_ff [3], d_in [3];
   logic signed [COORD_BITS-1:0] oc2_ff [3];
   logic [HALF_BITS-1:0]        r2_ff;

   logic signed [EW-1:0] oc1_e [3], dist_e [3], r_e;
   logic [2:0]           far, sep;

   always_comb begin
      r_e = $signed({{(EW-HALF_BITS){1'b0}}, r1_ff});
      for (int i = 0; i < 3; i++) begin
         oc1_e[i] = EW'(oc1_ff[i]);
         p_in[i]  = smin_ff[i] - omax_ff[i];
         q_in[i]  = smax_ff[i] - omin_ff[i];
         // distance from the sphere center to the box along this axis
         if (oc1_e[i] < smin_ff[i]) begin
            dist_e[i] = smin_ff[i] - oc1_e[i];
         end else if (oc1_e[i] > smax_ff[i]) begin
            dist_e[i] = oc1_e[i] - smax_ff[i];
         end else begin
            dist_e[i] = '0;
         end
         far[i]  = dist_e[i] > r_e;
         d_in[i] = dist_e[i][HALF_BITS-1:0];
         sep[i]  = (smin_ff[i] > omax_ff[i]) || (omin_ff[i] > smax_ff[i]);
      end
      s2_ctl_in.valid  = s1_ctl_ff.valid;
      s2_ctl_in.sphere = s1_ctl_ff.sphere;
      s2_ctl_in.miss   = s1_ctl_ff.sphere ? (|far) : (|sep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (adv) begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i]   <= p_in[i];
            q_ff[i]   <= q_in[i];
            d_ff[i]   <= d_in[i];
            oc2_ff[i] <= oc1_ff[i];
         end
         r2_ff <= r1_ff;
      end
   end

   assign ctl_out = s2_ctl_ff;
   assign p_out   = p_ff;
   assign q_out   = q_ff;
   assign d_out   = d_ff;
   assign oc_out  = oc2_ff;
   assign r_out   = r2_ff;

endmodule

// ===== rtl/aabbpb_gap.sv =====
// stage three: smaller-magnitude gap per axis and the squared distance terms
// depends on aabbpb_pkg
module aabbpb_gap import aabbpb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  stage_ctl_type                ctl_in,
   input  logic signed [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] p_in [3],
   input  logic signed [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] q_in [3],
   input  logic        [HALF_BITS-1:0]  d_in    [3],
   input  logic signed [COORD_BITS-1:0] oc_in   [3],
   input  logic        [HALF_BITS-1:0]  r_in,
   output stage_ctl_type                ctl_out,
   output logic signed [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] gap_out [3],
   output logic        [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] gmag_out [3],
   output logic        [SQ_BITS-1:0]    sq_out  [3],
   output logic        [SQ_BITS-1:0]    rsq_out,
   output logic signed [COORD_BITS-1:0] oc_out  [3]
);

   localparam int EW = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 3;

   stage_ctl_type               ctl_ff;
   logic signed [EW-1:0]        gap_ff [3], gap_in [3];
   logic [EW-1:0]               gmag_ff [3], gmag_in [3];
   logic [SQ_BITS-1:0]          sq_ff [3], sq_in [3];
   logic [SQ_BITS-1:0]          rsq_ff, rsq_in;
   logic signed [COORD_BITS-1:0] oc_ff [3];

   logic [EW-1:0] mp [3], mq [3];
   logic          take_p [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mp[i] = $unsigned((p_in[i] < 0) ? -p_in[i] : p_in[i]);
         mq[i] = $unsigned((q_in[i] < 0) ? -q_in[i] : q_in[i]);
         // sphere ties go to max minus min, box ties to min minus max
         take_p[i]  = ctl_in.sphere ? (mp[i] < mq[i]) : !(mq[i] < mp[i]);
         gap_in[i]  = take_p[i] ? p_in[i] : q_in[i];
         gmag_in[i] = take_p[i] ? mp[i] : mq[i];
         sq_in[i]   = SQ_BITS'(d_in[i]) * SQ_BITS'(d_in[i]);
      end
      rsq_in = SQ_BITS'(r_in) * SQ_BITS'(r_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            gap_ff[i]  <= gap_in[i];
            gmag_ff[i] <= gmag_in[i];
            sq_ff[i]   <= sq_in[i];
            oc_ff[i]   <= oc_in[i];
         end
         rsq_ff <= rsq_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign gap_out  = gap_ff;
   assign gmag_out = gmag_ff;
   assign sq_out   = sq_ff;
   assign rsq_out  = rsq_ff;
   assign oc_out   = oc_ff;

endmodule

// ===== rtl/aabbpb_resolve.sv =====
// stages four and five: hit decision, axis choice, moved center and output saturation
// depends on aabbpb_pkg; its stage five registers are the result register of the block
module aabbpb_resolve import aabbpb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  stage_ctl_type                ctl_in,
   input  logic signed [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] gap_in [3],
   input  logic        [((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS)+2:0] gmag_in [3],
   input  logic        [SQ_BITS-1:0]    sq_in   [3],
   input  logic        [SQ_BITS-1:0]    rsq_in,
   input  logic signed [COORD_BITS-1:0] oc_in   [3],
   output logic                         out_valid,
   output logic                         out_hit,
   output logic signed [COORD_BITS-1:0] out_push  [3],
   output logic signed [COORD_BITS-1:0] out_moved [3]
);

   localparam int EW = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 3;
   localparam int MW = EW + 1;

   // stage four
   logic                        v4_ff, hit4_ff, hit4_in;
   logic signed [EW-1:0]        push4_ff [3], push4_in [3];
   logic signed [COORD_BITS-1:0] oc4_ff [3];

   logic [DIST_BITS-1:0] dist2;
   logic [1:0]           axis;
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   always_comb begin
      dist2 = DIST_BITS'(sq_in[0]) + DIST_BITS'(sq_in[1]) + DIST_BITS'(sq_in[2]);
      hit4_in = !ctl_in.miss && (!ctl_in.sphere || (dist2 <= DIST_BITS'(rsq_in)));
      // least gap wins, x before z before y
      if ((gmag_in[0] <= gmag_in[1]) && (gmag_in[0] <= gmag_in[2])) begin
         axis = AXIS_X;
      end else if ((gmag_in[2] <= gmag_in[0]) && (gmag_in[2] <= gmag_in[1])) begin
         axis = AXIS_Z;
      end else begin
         axis = AXIS_Y;
      end
      for (int i = 0; i < 3; i++) begin
         push4_in[i] = (hit4_in && (axis == 2'(i))) ? gap_in[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit4_ff <= hit4_in;
         for (int i = 0; i < 3; i++) begin
            push4_ff[i] <= push4_in[i];
            oc4_ff[i]   <= oc_in[i];
         end
      end
   end

   // stage five
   logic                        v5_ff, hit5_ff;
   logic signed [COORD_BITS-1:0] push5_ff [3], push5_in [3];
   logic signed [COORD_BITS-1:0] moved5_ff [3], moved5_in [3];
   logic signed [MW-1:0]        msum [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         msum[i] = MW'(oc4_ff[i]) + MW'(push4_ff[i]);
         // clamp to the signed coordinate range
         if (push4_ff[i][EW-1:COORD_BITS-1] == {(EW-COORD_BITS+1){push4_ff[i][EW-1]}}) begin
            push5_in[i] = push4_ff[i][COORD_BITS-1:0];
         end else begin
            push5_in[i] = {push4_ff[i][EW-1], {(COORD_BITS-1){~push4_ff[i][EW-1]}}};
         end
         if (msum[i][MW-1:COORD_BITS-1] == {(MW-COORD_BITS+1){msum[i][MW-1]}}) begin
            moved5_in[i] = msum[i][COORD_BITS-1:0];
         end else begin
            moved5_in[i] = {msum[i][MW-1], {(COORD_BITS-1){~msum[i][MW-1]}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit5_ff <= hit4_ff;
         for (int i = 0; i < 3; i++) begin
            push5_ff[i]  <= push5_in[i];
            moved5_ff[i] <= moved5_in[i];
         end
      end
   end

   assign out_valid = v5_ff;
   assign out_hit   = hit5_ff;
   assign out_push  = push5_ff;
   assign out_moved = moved5_ff;

endmodule

// ===== rtl/aabbpb_checker.sv =====
// port-level checks for the push-back resolver, attached to the top level by bind
// depends on aabbpb_pkg and aabb_push_back_resolver
module aabbpb_port_checker import aabbpb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_hit,
   input logic signed [COORD_BITS-1:0] rsp_push_x,
   input logic signed [COORD_BITS-1:0] rsp_push_y,
   input logic signed [COORD_BITS-1:0] rsp_push_z
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input side is taken exactly when the result side can move
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready out of step with result register");

   // a miss pushes nowhere
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_push_x == 0 && rsp_push_y == 0 && rsp_push_z == 0))
      else $error("nonzero push on a miss");

   // at most one axis is pushed
   a_one_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_push_x != 0, rsp_push_y != 0, rsp_push_z != 0}) <= 1))
      else $error("push on more than one axis");

   // a stalled result holds its valid, hit and push_x
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit) && $stable(rsp_push_x)))
      else $error("stalled result changed");

endmodule

bind aabb_push_back_resolver aabbpb_port_checker #(.COORD_BITS(COORD_BITS)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_hit    (rsp_hit),
   .rsp_push_x (rsp_push_x),
   .rsp_push_y (rsp_push_y),
   .rsp_push_z (rsp_push_z)
);
